### sv/irm_pkg.sv
package irm_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 16;

    localparam int KEY_FIELD_W    = 32;
    localparam int VALUE_FIELD_W  = 16;
    localparam int STATUS_W       = 2;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ASSIGN = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PUSH_START,
        ST_PUSH_STOP,
        ST_FINISH,
        ST_DONE
    } state_t;

endpackage

### sv/interval_range_map_core.sv
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   command, range_start, range_stop,
//                                          assign_value, query_key
// result    out        out_valid/out_stall mapped_value, status
// config    in         cfg_write_en        cfg_write_data (default value)
//
// One request at a time; each breakpoint visited takes a RAM read (ST_READ) and then
// a compare (ST_EVAL) through one RAM read port and one pair of key comparators.
// Reset (rst_n low, asynchronous) empties the table and clears the default.
// Hold a stalled result; one more request is taken.
module interval_range_map_core #(
    parameter int CAPACITY   = irm_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = irm_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = irm_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [irm_pkg::KEY_FIELD_W-1:0]     range_start,
    input  logic [irm_pkg::KEY_FIELD_W-1:0]     range_stop,
    input  logic [irm_pkg::VALUE_FIELD_W-1:0]   assign_value,
    input  logic [irm_pkg::KEY_FIELD_W-1:0]     query_key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [irm_pkg::VALUE_FIELD_W-1:0]   mapped_value,
    output logic [irm_pkg::STATUS_W-1:0]        status,
    input  logic                                cfg_write_en,
    input  logic [irm_pkg::VALUE_FIELD_W-1:0]   cfg_write_data
);

    localparam int DEPTH  = 2 * CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = KEY_BITS + VALUE_BITS;

    irm_pkg::state_t state_reg, state_next;

    // Two banks in one RAM: the live table and the one being rebuilt.
    logic                         bank_reg, bank_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             work_count_reg, work_count_next;
    logic                         full_reg, full_next;
    logic                         mid_reg, mid_next;
    logic [VALUE_BITS-1:0]        last_reg, last_next;
    logic [VALUE_BITS-1:0]        sv_reg, sv_next;
    logic                         cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]          start_reg, start_next;
    logic [KEY_BITS-1:0]          stop_reg, stop_next;
    logic [VALUE_BITS-1:0]        val_reg, val_next;
    logic [VALUE_BITS-1:0]        default_reg;
    logic [irm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         out_valid_reg, out_valid_next;
    logic [irm_pkg::VALUE_FIELD_W-1:0] mapped_reg, mapped_next;
    logic [irm_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                  rd_en, wr_en;
    logic [ADDR_W-1:0]     rd_addr, wr_addr;
    logic [WORD_W-1:0]     rd_data;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  push_en;
    logic [KEY_BITS-1:0]   push_key;
    logic [VALUE_BITS-1:0] push_val;
    logic                  lt_start, le_stop;
    logic [KEY_BITS-1:0]   in_start, in_stop, in_query;

    assign in_start = KEY_BITS'(range_start);
    assign in_stop  = KEY_BITS'(range_stop);
    assign in_query = KEY_BITS'(query_key);

    assign rd_key = rd_data[WORD_W-1:VALUE_BITS];
    assign rd_val = rd_data[VALUE_BITS-1:0];

    // Shared compare pair; a lookup parks its key in the stop register.
    assign lt_start = rd_key < start_reg;
    assign le_stop  = rd_key <= stop_reg;

    assign rd_addr = bank_reg ? ADDR_W'(CAPACITY) + ADDR_W'(idx_reg[IDX_W-1:0])
                              : ADDR_W'(idx_reg[IDX_W-1:0]);
    assign wr_addr = bank_reg ? ADDR_W'(work_count_reg[IDX_W-1:0])
                              : ADDR_W'(CAPACITY) + ADDR_W'(work_count_reg[IDX_W-1:0]);

    irm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({push_key, push_val}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall     = (state_reg != irm_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign mapped_value = mapped_reg;
    assign status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irm_pkg::ST_IDLE;
            bank_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            default_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                default_reg <= VALUE_BITS'(cfg_write_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        work_count_reg <= work_count_next;
        full_reg       <= full_next;
        mid_reg        <= mid_next;
        last_reg       <= last_next;
        sv_reg         <= sv_next;
        cmd_reg        <= cmd_next;
        start_reg      <= start_next;
        stop_reg       <= stop_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        mapped_reg     <= mapped_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        work_count_next = work_count_reg;
        full_next       = full_reg;
        mid_next        = mid_reg;
        last_next       = last_reg;
        sv_next         = sv_reg;
        cmd_next        = cmd_reg;
        start_next      = start_reg;
        stop_next       = stop_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        mapped_next     = mapped_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        push_en         = 1'b0;
        push_key        = '0;
        push_val        = '0;

        // Drop the result once the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            irm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    start_next      = in_start;
                    stop_next       = (command == irm_pkg::CMD_LOOKUP) ? in_query : in_stop;
                    val_next        = VALUE_BITS'(assign_value);
                    idx_next        = '0;
                    work_count_next = '0;
                    full_next       = 1'b0;
                    mid_next        = 1'b0;
                    sv_next         = default_reg;
                    last_next       = default_reg;
                    res_status_next = irm_pkg::STATUS_DONE;
                    if (command == irm_pkg::CMD_ASSIGN && !(in_start < in_stop))
                    begin
                        res_status_next = irm_pkg::STATUS_EMPTY;
                        state_next      = irm_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = irm_pkg::ST_READ;
                    end
                end
            end
            irm_pkg::ST_READ:
            begin
                if (idx_reg == count_reg)
                begin
                    if (cmd_reg == irm_pkg::CMD_LOOKUP)
                    begin
                        state_next = irm_pkg::ST_DONE;
                    end
                    else if (!mid_reg)
                    begin
                        mid_next   = 1'b1;
                        state_next = irm_pkg::ST_PUSH_START;
                    end
                    else
                    begin
                        state_next = irm_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = irm_pkg::ST_EVAL;
                end
            end
            irm_pkg::ST_EVAL:
            begin
                if (cmd_reg == irm_pkg::CMD_LOOKUP)
                begin
                    if (le_stop)
                    begin
                        sv_next    = rd_val;
                        idx_next   = idx_reg + 1'b1;
                        state_next = irm_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = irm_pkg::ST_DONE;
                    end
                end
                else if (lt_start)
                begin
                    push_en    = 1'b1;
                    push_key   = rd_key;
                    push_val   = rd_val;
                    sv_next    = rd_val;
                    idx_next   = idx_reg + 1'b1;
                    state_next = irm_pkg::ST_READ;
                end
                else if (le_stop)
                begin
                    // Covered by the new interval: track its value at stop.
                    sv_next    = rd_val;
                    idx_next   = idx_reg + 1'b1;
                    state_next = irm_pkg::ST_READ;
                end
                else if (!mid_reg)
                begin
                    // Insert start and stop, then revisit this entry.
                    mid_next   = 1'b1;
                    state_next = irm_pkg::ST_PUSH_START;
                end
                else
                begin
                    push_en    = 1'b1;
                    push_key   = rd_key;
                    push_val   = rd_val;
                    idx_next   = idx_reg + 1'b1;
                    state_next = irm_pkg::ST_READ;
                end
            end
            irm_pkg::ST_PUSH_START:
            begin
                push_en    = 1'b1;
                push_key   = start_reg;
                push_val   = val_reg;
                state_next = irm_pkg::ST_PUSH_STOP;
            end
            irm_pkg::ST_PUSH_STOP:
            begin
                push_en    = 1'b1;
                push_key   = stop_reg;
                push_val   = sv_reg;
                state_next = irm_pkg::ST_READ;
            end
            irm_pkg::ST_FINISH:
            begin
                if (full_reg)
                begin
                    res_status_next = irm_pkg::STATUS_FULL;
                end
                else
                begin
                    bank_next  = ~bank_reg;
                    count_next = work_count_reg;
                end
                state_next = irm_pkg::ST_DONE;
            end
            irm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    mapped_next    = (cmd_reg == irm_pkg::CMD_LOOKUP)
                                   ? irm_pkg::VALUE_FIELD_W'(sv_reg) : '0;
                    state_next     = irm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = irm_pkg::ST_IDLE;
            end
        endcase

        // Canonical append: skip a repeat of the previous value, flag overflow.
        if (push_en && push_val != last_reg)
        begin
            last_next = push_val;
            if (work_count_reg < CNT_W'(CAPACITY))
            begin
                wr_en           = 1'b1;
                work_count_next = work_count_reg + 1'b1;
            end
            else
            begin
                full_next = 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (work_count_reg < CNT_W'(CAPACITY)))
        else $error("write past end of work bank");

    a_finish_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == irm_pkg::ST_FINISH) |-> mid_reg)
        else $error("assign finished without inserting interval");

    a_bank_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> ($past(state_reg) == irm_pkg::ST_FINISH))
        else $error("bank switched outside finish");

endmodule

### sv/irm_ram.sv
module irm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
